FILE: design/i2c_master_byte_engine_macros.svh
// assertion macros used by the checker file
`ifndef I2C_MASTER_BYTE_ENGINE_MACROS_SVH
`define I2C_MASTER_BYTE_ENGINE_MACROS_SVH

// check sampled on every rising edge, reset included
`define I2CM_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

// check sampled on rising edges outside reset
`define I2CM_ASSERT_RUN(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

`endif

FILE: design/i2cm_pkg.sv
// shared types, codes and constants of the i2c master byte engine
package i2cm_pkg;

  localparam int DATA_BITS = 8;
  localparam int PHASE_W   = 16;
  localparam int BITCNT_W  = 4;

  localparam logic [2:0] CMD_NONE  = 3'd0;
  localparam logic [2:0] CMD_START = 3'd1;
  localparam logic [2:0] CMD_ADDR  = 3'd2;
  localparam logic [2:0] CMD_WRITE = 3'd3;
  localparam logic [2:0] CMD_READ  = 3'd4;
  localparam logic [2:0] CMD_STOP  = 3'd5;

  localparam logic [DATA_BITS-1:0] RD_DIR_BIT = 8'h01;

  typedef struct packed {
    logic [2:0]           cmd;
    logic [DATA_BITS-1:0] data_byte;
    logic                 read_dir;
    logic                 last_byte;
    logic                 sda_in;
  } in_item_t;

  typedef struct packed {
    logic                 scl_out;
    logic                 sda_out;
    logic                 busy_res;
    logic                 done_res;
    logic [DATA_BITS-1:0] rx_byte;
    logic                 nack_seen;
    logic                 cmd_ignored;
  } res_item_t;

  typedef enum logic [1:0] {
    OP_NONE,
    OP_START,
    OP_BYTE,
    OP_STOP
  } op_kind_t;

  // classified tick as handed from the front to the engine
  typedef struct packed {
    op_kind_t             kind;
    logic [DATA_BITS-1:0] value;
    logic                 is_read;
    logic                 nack;
    logic                 sda_in;
  } op_t;

endpackage

FILE: design/i2c_master_byte_engine.sv
// top level of the i2c master byte engine: front queue, phase engine, result queue
//
// channel   direction  handshake                  payload
// item      in         push / full                in_item_t (cmd, data, sda sample)
// result    out        empty / pop                res_item_t (lines, status, rx byte)
// cfg       in         cfg_valid / cfg_ready      phase_ticks, 16 bits
//
// one tick per clock cycle while neither side stalls; a tick's result is
// registered in the front queue, then in the result queue, before it is visible
// the engine state update is the loop that sets this rate
// rst is synchronous; it clears both queues and returns the lines to released
// either side may stall: the two-entry queues absorb backpressure
// and full rises only once both queues hold waiting transfers
module i2c_master_byte_engine
  import i2cm_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  // tick input queue
  input  logic               push,
  output logic               full,
  input  in_item_t           item,
  // result queue
  output logic               empty,
  input  logic               pop,
  output res_item_t          result,
  // phase length register
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [PHASE_W-1:0] cfg_data
);

  op_t       op;
  logic      op_valid;
  logic      op_take;
  res_item_t res;
  logic      res_valid;
  logic      res_ready;

  // register write is always accepted
  assign cfg_ready = 1'b1;

  // front: decode command, fold read direction into the address byte
  i2cm_front u_front (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .full     (full),
    .item     (item),
    .op_valid (op_valid),
    .op_take  (op_take),
    .op       (op)
  );

  // engine: advances one tick per transfer from the front queue
  i2cm_engine u_engine (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_data  (cfg_data),
    .op_valid  (op_valid),
    .op        (op),
    .op_take   (op_take),
    .res_ready (res_ready),
    .res_valid (res_valid),
    .res       (res)
  );

  // result side buffering, decouples pop from the engine
  i2cm_out_buf u_out_buf (
    .clk       (clk),
    .rst       (rst),
    .res_valid (res_valid),
    .res       (res),
    .res_ready (res_ready),
    .empty     (empty),
    .pop       (pop),
    .result    (result)
  );

endmodule

FILE: design/i2cm_front.sv
// front: classifies incoming ticks and queues them for the engine
module i2cm_front
  import i2cm_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     push,
  output logic     full,
  input  in_item_t item,
  output logic     op_valid,
  input  logic     op_take,
  output op_t      op
);

  op_t        op_new;
  op_t        slots [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       do_push;
  logic       do_pop;

  // decode the command into an engine operation
  always_comb begin
    op_new.kind    = OP_NONE;
    op_new.value   = '0;
    op_new.is_read = 1'b0;
    op_new.nack    = 1'b0;
    op_new.sda_in  = item.sda_in;
    case (item.cmd)
      CMD_START: op_new.kind = OP_START;
      CMD_ADDR: begin
        op_new.kind  = OP_BYTE;
        op_new.value = item.data_byte | (item.read_dir ? RD_DIR_BIT : '0);
      end
      CMD_WRITE: begin
        op_new.kind  = OP_BYTE;
        op_new.value = item.data_byte;
      end
      CMD_READ: begin
        op_new.kind    = OP_BYTE;
        op_new.is_read = 1'b1;
        op_new.nack    = item.last_byte;
      end
      CMD_STOP: op_new.kind = OP_STOP;
      default:  op_new.kind = OP_NONE;
    endcase
  end

  assign full     = (count == 2'd2);
  assign op_valid = (count != 2'd0);
  assign op       = slots[rd_ptr];
  assign do_push  = push && !full;
  assign do_pop   = op_take && op_valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= op_new;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (do_push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (do_pop) begin
        rd_ptr <= ~rd_ptr;
      end
      count <= count + 2'(do_push) - 2'(do_pop);
    end
  end

endmodule

FILE: design/i2cm_engine.sv
// back end: scl/sda phase sequencer, one tick per cycle while a tick waits and the result queue has room
module i2cm_engine
  import i2cm_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [PHASE_W-1:0] cfg_data,
  input  logic               op_valid,
  input  op_t                op,
  output logic               op_take,
  input  logic               res_ready,
  output logic               res_valid,
  output res_item_t          res
);

  typedef enum logic [3:0] {
    PH_IDLE,
    PH_ST_REL,
    PH_ST_SCLH,
    PH_ST_SDAL,
    PH_ST_SCLL,
    PH_BIT_LO,
    PH_BIT_HI,
    PH_ACK_LO,
    PH_ACK_HI,
    PH_BYTE_END,
    PH_SP_LO,
    PH_SP_SCLH,
    PH_SP_SDAH
  } phase_t;

  logic [PHASE_W-1:0]   phase_ticks;
  phase_t               phase_state, phase_state_next;
  logic [BITCNT_W-1:0]  bit_count, bit_count_next;
  logic [DATA_BITS-1:0] shift_reg, shift_reg_next;
  logic [PHASE_W-1:0]   tick_count, tick_count_next;
  logic                 nack_flag, nack_flag_next;
  logic                 answer_nack, answer_nack_next;
  logic                 scl_level, scl_level_next;
  logic                 sda_level, sda_level_next;
  logic                 is_read, is_read_next;
  logic [DATA_BITS-1:0] rx_hold, rx_hold_next;
  logic                 done, ignored;
  logic [PHASE_W-1:0]   limit;
  logic                 fire;

  assign fire      = op_valid && res_ready;
  assign op_take   = fire;
  assign res_valid = fire;
  assign limit     = (phase_ticks == '0) ? PHASE_W'(1) : phase_ticks;

  always_comb begin
    phase_state_next = phase_state;
    bit_count_next   = bit_count;
    shift_reg_next   = shift_reg;
    tick_count_next  = tick_count;
    nack_flag_next   = nack_flag;
    answer_nack_next = answer_nack;
    scl_level_next   = scl_level;
    sda_level_next   = sda_level;
    is_read_next     = is_read;
    rx_hold_next     = rx_hold;
    done             = 1'b0;
    ignored          = 1'b0;

    // command launch, or drop when busy
    if (op.kind != OP_NONE) begin
      if (phase_state != PH_IDLE) begin
        ignored = 1'b1;
      end else begin
        tick_count_next = '0;
        case (op.kind)
          OP_START: begin
            nack_flag_next   = 1'b0;
            phase_state_next = PH_ST_REL;
          end
          OP_BYTE: begin
            shift_reg_next   = op.value;
            is_read_next     = op.is_read;
            answer_nack_next = op.nack;
            bit_count_next   = '0;
            phase_state_next = PH_BIT_LO;
          end
          OP_STOP: phase_state_next = PH_SP_LO;
          default: phase_state_next = phase_state;
        endcase
      end
    end

    if (phase_state_next != PH_IDLE) begin
      // drive lines for the current phase
      case (phase_state_next)
        PH_ST_REL:  sda_level_next = 1'b1;
        PH_ST_SCLH: scl_level_next = 1'b1;
        PH_ST_SDAL: sda_level_next = 1'b0;
        PH_ST_SCLL: scl_level_next = 1'b0;
        PH_BIT_LO: begin
          scl_level_next = 1'b0;
          sda_level_next = is_read_next | shift_reg_next[DATA_BITS-1];
        end
        PH_BIT_HI:  scl_level_next = 1'b1;
        PH_ACK_LO: begin
          scl_level_next = 1'b0;
          sda_level_next = is_read_next ? answer_nack_next : 1'b1;
        end
        PH_ACK_HI:   scl_level_next = 1'b1;
        PH_BYTE_END: scl_level_next = 1'b0;
        PH_SP_LO: begin
          scl_level_next = 1'b0;
          sda_level_next = 1'b0;
        end
        PH_SP_SCLH: scl_level_next = 1'b1;
        PH_SP_SDAH: sda_level_next = 1'b1;
        default:    scl_level_next = scl_level_next;
      endcase

      tick_count_next = tick_count_next + PHASE_W'(1);

      // phase end
      if (tick_count_next >= limit) begin
        tick_count_next = '0;
        case (phase_state_next)
          PH_ST_REL:  phase_state_next = PH_ST_SCLH;
          PH_ST_SCLH: phase_state_next = PH_ST_SDAL;
          PH_ST_SDAL: phase_state_next = PH_ST_SCLL;
          PH_BIT_LO:  phase_state_next = PH_BIT_HI;
          PH_BIT_HI: begin
            shift_reg_next   = {shift_reg_next[DATA_BITS-2:0], is_read_next & op.sda_in};
            bit_count_next   = bit_count_next + BITCNT_W'(1);
            phase_state_next = (bit_count_next >= BITCNT_W'(DATA_BITS)) ? PH_ACK_LO
                                                                         : PH_BIT_LO;
          end
          PH_ACK_LO: phase_state_next = PH_ACK_HI;
          PH_ACK_HI: begin
            if (!is_read_next && op.sda_in) begin
              nack_flag_next = 1'b1;
            end
            phase_state_next = PH_BYTE_END;
          end
          PH_BYTE_END: begin
            if (is_read_next) begin
              rx_hold_next = shift_reg_next;
            end
            phase_state_next = PH_IDLE;
            done             = 1'b1;
          end
          PH_SP_LO:   phase_state_next = PH_SP_SCLH;
          PH_SP_SCLH: phase_state_next = PH_SP_SDAH;
          default: begin
            // end of start or stop sequence
            phase_state_next = PH_IDLE;
            done             = 1'b1;
          end
        endcase
      end
    end
  end

  always_comb begin
    res.scl_out     = scl_level_next;
    res.sda_out     = sda_level_next;
    res.busy_res    = (phase_state_next != PH_IDLE);
    res.done_res    = done;
    res.rx_byte     = rx_hold_next;
    res.nack_seen   = nack_flag_next;
    res.cmd_ignored = ignored;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase_ticks <= PHASE_W'(1);
      phase_state <= PH_IDLE;
      bit_count   <= '0;
      shift_reg   <= '0;
      tick_count  <= '0;
      nack_flag   <= 1'b0;
      answer_nack <= 1'b0;
      scl_level   <= 1'b1;
      sda_level   <= 1'b1;
      is_read     <= 1'b0;
      rx_hold     <= '0;
    end else begin
      if (cfg_we) begin
        phase_ticks <= cfg_data;
      end
      if (fire) begin
        phase_state <= phase_state_next;
        bit_count   <= bit_count_next;
        shift_reg   <= shift_reg_next;
        tick_count  <= tick_count_next;
        nack_flag   <= nack_flag_next;
        answer_nack <= answer_nack_next;
        scl_level   <= scl_level_next;
        sda_level   <= sda_level_next;
        is_read     <= is_read_next;
        rx_hold     <= rx_hold_next;
      end
    end
  end

endmodule

FILE: design/i2cm_out_buf.sv
// two-entry result queue in front of the result port
module i2cm_out_buf
  import i2cm_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      res_valid,
  input  res_item_t res,
  output logic      res_ready,
  output logic      empty,
  input  logic      pop,
  output res_item_t result
);

  res_item_t  slots [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       do_push;
  logic       do_pop;

  assign res_ready = (count != 2'd2);
  assign empty     = (count == 2'd0);
  assign result    = slots[rd_ptr];
  assign do_push   = res_valid && res_ready;
  assign do_pop    = pop && !empty;

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= res;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (do_push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (do_pop) begin
        rd_ptr <= ~rd_ptr;
      end
      count <= count + 2'(do_push) - 2'(do_pop);
    end
  end

endmodule

FILE: design/i2cm_checker.sv
// port-level checks of the i2c master byte engine, bound to the top level
`include "i2c_master_byte_engine_macros.svh"

module i2cm_checker
  import i2cm_pkg::*;
(
  input logic      clk,
  input logic      rst,
  input logic      full,
  input logic      empty,
  input logic      pop,
  input res_item_t result
);

  `I2CM_ASSERT_ALWAYS(a_reset_clears, rst |=> (empty && !full), "queues not cleared by reset")
  `I2CM_ASSERT_RUN(a_full_needs_backlog, full |-> !empty, "input full without waiting result")
  `I2CM_ASSERT_RUN(a_done_not_busy, (!empty && result.done_res) |-> !result.busy_res,
                   "done while busy")
  `I2CM_ASSERT_RUN(a_stall_holds, (!empty && !pop) |=> (!empty && $stable(result)),
                   "result changed during stall")

endmodule

bind i2c_master_byte_engine i2cm_checker u_checker (
  .clk    (clk),
  .rst    (rst),
  .full   (full),
  .empty  (empty),
  .pop    (pop),
  .result (result)
);
